/* src/ctt_pkg.sv */
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, constants and helpers for the connection timer table.
// ----------------------------------------------------------------------------
package ctt_pkg;

	localparam int NUM_CONN = 16;
	localparam int SLOT_W   = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;
	localparam int REM_W    = 33;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic signed [REM_W-1:0] REM_MAX = 33'sh0_FFFF_FFFF;
	localparam logic signed [REM_W-1:0] REM_MIN = 33'sh1_0000_0000;

	typedef enum logic [2:0] {
		KIND_TICK   = 3'd0,
		KIND_SET_TW = 3'd1,
		KIND_SET_RT = 3'd2,
		KIND_UPD_RT = 3'd3,
		KIND_UNSET  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		EV_TW_EXPIRED = 3'd0,
		EV_RT_DUE     = 3'd1,
		EV_SCAN_DONE  = 3'd2,
		EV_CMD_DONE   = 3'd3,
		EV_UPD_OK     = 3'd4,
		EV_UPD_REFUSE = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		REG_SCAN_INTERVAL = 2'd0,
		REG_TW_TIMEOUT    = 2'd1,
		REG_RT_INITIAL    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [23:0] scan_interval;
		logic [30:0] timewait_timeout;
		logic [30:0] retrans_initial;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic slot_clr;
		logic slot_inc;
		logic step_tw;
		logic step_rt;
		logic step_done;
		logic step_cmd;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic last_slot;
	} sts_t;

	// subtract the scan interval, clamping at the lower field limit
	function automatic logic signed [REM_W-1:0] sat_sub(
		input logic signed [REM_W-1:0] v,
		input logic [23:0] d
	);
		logic signed [REM_W:0] r;
		r = {v[REM_W-1], v} - $signed({{(REM_W-24+1){1'b0}}, d});
		if (r[REM_W] && !r[REM_W-1])
			sat_sub = REM_MIN;
		else
			sat_sub = r[REM_W-1:0];
	endfunction

	function automatic logic le_zero(input logic signed [REM_W-1:0] v);
		le_zero = v[REM_W-1] || (v == '0);
	endfunction

endpackage

/* src/ctt_cfg.sv */
// ----------------------------------------------------------------------------
// ctt_cfg
// APB register block holding scan interval and reload values.
// ----------------------------------------------------------------------------
module ctt_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ctt_pkg::ADDR_W-1:0] paddr,
	input  logic [ctt_pkg::DATA_W-1:0] pwdata,
	output logic [ctt_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output ctt_pkg::cfg_t              cfg
);
	import ctt_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_interval    <= 24'd10000;
			cfg_q.timewait_timeout <= 31'd2000000;
			cfg_q.retrans_initial  <= 31'd200000;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_SCAN_INTERVAL: cfg_q.scan_interval    <= pwdata[23:0];
				REG_TW_TIMEOUT:    cfg_q.timewait_timeout <= pwdata[30:0];
				REG_RT_INITIAL:    cfg_q.retrans_initial  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_SCAN_INTERVAL: prdata = {8'd0, cfg_q.scan_interval};
			REG_TW_TIMEOUT:    prdata = {1'b0, cfg_q.timewait_timeout};
			REG_RT_INITIAL:    prdata = {1'b0, cfg_q.retrans_initial};
			default:           prdata = '0;
		endcase
	end

endmodule

/* src/ctt_dp.sv */
// ----------------------------------------------------------------------------
// ctt_dp
// Timer state, per-slot update arithmetic and the result register.
// ----------------------------------------------------------------------------
module ctt_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ctt_pkg::cfg_t       cfg,
	input  ctt_pkg::ctl_t       ctl,
	output ctt_pkg::sts_t       sts,
	input  logic [2:0]          kind,
	input  logic [3:0]          conn_index,
	input  logic [4:0]          backoff_exponent,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          result_conn,
	output logic [2:0]          result_event,
	output logic                last
);
	import ctt_pkg::*;

	logic [2:0]              kind_q;
	logic [3:0]              idx_q;
	logic [4:0]              sh_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [NUM_CONN-1:0]     tw_en_q;
	logic [NUM_CONN-1:0]     rt_en_q;
	logic signed [REM_W-1:0] tw_rem_q [NUM_CONN];
	logic signed [REM_W-1:0] rt_rem_q [NUM_CONN];

	logic                    out_valid_q;
	logic [3:0]              out_conn_q;
	logic [2:0]              out_event_q;
	logic                    out_last_q;

	logic [SLOT_W-1:0]       cmd_slot;
	logic                    cmd_ok;
	logic signed [REM_W-1:0] tw_nv;
	logic signed [REM_W-1:0] rt_nv;
	logic [62:0]             shifted;
	logic signed [REM_W-1:0] upd_val;
	logic                    upd_ok;
	logic                    tw_fire;
	logic                    rt_fire;
	logic                    emit;
	logic [3:0]              emit_conn;
	event_t                  emit_ev;
	logic                    emit_last;

	assign cmd_slot = SLOT_W'(idx_q);
	assign cmd_ok   = 32'(idx_q) < NUM_CONN;
	assign tw_nv    = sat_sub(tw_rem_q[slot_q], cfg.scan_interval);
	assign rt_nv    = sat_sub(rt_rem_q[slot_q], cfg.scan_interval);
	assign tw_fire  = tw_en_q[slot_q] && le_zero(tw_nv);
	assign rt_fire  = rt_en_q[slot_q] && le_zero(rt_nv);

	// backoff reload, clamped at the upper field limit
	assign shifted = {32'd0, cfg.retrans_initial} << sh_q;
	assign upd_val = (|shifted[62:32]) ? REM_MAX : $signed({1'b0, shifted[31:0]});
	assign upd_ok  = cmd_ok && rt_en_q[cmd_slot] && le_zero(rt_rem_q[cmd_slot]);

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.last_slot = (slot_q == SLOT_W'(NUM_CONN - 1));

	always_comb begin
		emit      = 1'b0;
		emit_conn = idx_q;
		emit_ev   = EV_CMD_DONE;
		emit_last = 1'b1;
		if (ctl.step_tw) begin
			emit      = tw_fire;
			emit_conn = 4'(slot_q);
			emit_ev   = EV_TW_EXPIRED;
			emit_last = 1'b0;
		end else if (ctl.step_rt) begin
			emit      = rt_fire;
			emit_conn = 4'(slot_q);
			emit_ev   = EV_RT_DUE;
			emit_last = 1'b0;
		end else if (ctl.step_done) begin
			emit      = 1'b1;
			emit_conn = 4'd0;
			emit_ev   = EV_SCAN_DONE;
		end else if (ctl.step_cmd) begin
			emit = 1'b1;
			if (kind_q == KIND_UPD_RT)
				emit_ev = upd_ok ? EV_UPD_OK : EV_UPD_REFUSE;
		end
	end

	// command word and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_TICK;
			idx_q  <= '0;
			sh_q   <= '0;
			slot_q <= '0;
		end else begin
			if (ctl.latch) begin
				kind_q <= kind;
				idx_q  <= conn_index;
				sh_q   <= backoff_exponent;
			end
			if (ctl.slot_clr)
				slot_q <= '0;
			else if (ctl.slot_inc)
				slot_q <= slot_q + 1'b1;
		end
	end

	// enable flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_en_q <= '0;
			rt_en_q <= '0;
		end else begin
			if (ctl.step_tw && tw_fire)
				tw_en_q[slot_q] <= 1'b0;
			if (ctl.step_cmd && cmd_ok) begin
				if (kind_q == KIND_SET_TW)
					tw_en_q[cmd_slot] <= 1'b1;
				if (kind_q == KIND_SET_RT)
					rt_en_q[cmd_slot] <= 1'b1;
				if (kind_q == KIND_UNSET)
					rt_en_q[cmd_slot] <= 1'b0;
			end
		end
	end

	// remaining times, only read while enabled
	always_ff @(posedge clk) begin
		if (ctl.step_tw && tw_en_q[slot_q])
			tw_rem_q[slot_q] <= tw_nv;
		if (ctl.step_rt && rt_en_q[slot_q])
			rt_rem_q[slot_q] <= rt_nv;
		if (ctl.step_cmd && cmd_ok) begin
			if (kind_q == KIND_SET_TW)
				tw_rem_q[cmd_slot] <= $signed({2'b00, cfg.timewait_timeout});
			if (kind_q == KIND_SET_RT)
				rt_rem_q[cmd_slot] <= $signed({2'b00, cfg.retrans_initial});
			if (kind_q == KIND_UPD_RT && upd_ok)
				rt_rem_q[cmd_slot] <= upd_val;
		end
	end

	// result register: load on emit, drop once the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_conn_q  <= emit_conn;
			out_event_q <= emit_ev;
			out_last_q  <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_conn  = out_conn_q;
	assign result_event = out_event_q;
	assign last         = out_last_q;

endmodule

/* src/ctt_ctrl.sv */
// ----------------------------------------------------------------------------
// ctt_ctrl
// Sequencer: accepts a word, walks the slots on a tick, runs commands.
// ----------------------------------------------------------------------------
module ctt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    kind,
	input  ctt_pkg::sts_t sts,
	output ctt_pkg::ctl_t ctl
);
	import ctt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_TW   = 5'b00010,
		ST_RT   = 5'b00100,
		ST_DONE = 5'b01000,
		ST_CMD  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.latch    = 1'b1;
					ctl.slot_clr = 1'b1;
					state_d      = (kind == KIND_TICK) ? ST_TW : ST_CMD;
				end
			end
			ST_TW: begin
				if (sts.out_free) begin
					ctl.step_tw = 1'b1;
					state_d     = ST_RT;
				end
			end
			ST_RT: begin
				if (sts.out_free) begin
					ctl.step_rt = 1'b1;
					if (sts.last_slot) begin
						state_d = ST_DONE;
					end else begin
						ctl.slot_inc = 1'b1;
						state_d      = ST_TW;
					end
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.step_done = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_CMD: begin
				if (sts.out_free) begin
					ctl.step_cmd = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* src/connection_timer_table.sv */
// A command's result word is registered in the command state once the output
// register is free; the next word is taken after the return to idle. A tick
// visits each slot with a time-wait step and then a retransmit step, and then
// registers the scan-done word; every step waits for a free output register,
// so output stalls hold the scan. The next word is taken back in idle.
// Reset clears all timer enables and restores the register defaults.
// ----------------------------------------------------------------------------
// connection_timer_table
// Per-connection time-wait and retransmit timers with exponential backoff.
// ----------------------------------------------------------------------------
module connection_timer_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ctt_pkg::ADDR_W-1:0] paddr,
	input  logic [ctt_pkg::DATA_W-1:0] pwdata,
	output logic [ctt_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 kind,
	input  logic [3:0]                 conn_index,
	input  logic [4:0]                 backoff_exponent,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [3:0]                 result_conn,
	output logic [2:0]                 result_event,
	output logic                       last
);
	import ctt_pkg::*;

	cfg_t cfg;
	ctl_t ctl;
	sts_t sts;

	ctt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ctt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.ctl      (ctl)
	);

	ctt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.ctl              (ctl),
		.sts              (sts),
		.kind             (kind),
		.conn_index       (conn_index),
		.backoff_exponent (backoff_exponent),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_conn      (result_conn),
		.result_event     (result_event),
		.last             (last)
	);

endmodule
